FILE: src/hsvg_pkg.sv
// hsvg_pkg: shared constants, lookup tables and helpers for the hsv to rgb gamma core
// no dependencies; compiled before every other file of the block
package hsvg_pkg;

  // hue sector bounds
  localparam logic [7:0] HUE_B1 = 8'd43;
  localparam logic [7:0] HUE_B2 = 8'd85;
  localparam logic [7:0] HUE_B3 = 8'd128;
  localparam logic [7:0] HUE_B4 = 8'd171;
  localparam logic [7:0] HUE_B5 = 8'd213;

  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [7:0] SAT_BUMP_LIMIT = 8'd128;

  // saturation blend: c*s + 255*(256-s) == 255*256 - s*(255-c)
  localparam logic [16:0] BLEND_TOP = 17'd65280;

  // palette weights
  localparam logic [7:0] PAL_R_WEIGHT = 8'd36;
  localparam logic [7:0] PAL_G_WEIGHT = 8'd6;

  // palette quantiser thresholds: floor(c*5/255) == floor(c/51)
  localparam logic [7:0] Q_T1 = 8'd51;
  localparam logic [7:0] Q_T2 = 8'd102;
  localparam logic [7:0] Q_T3 = 8'd153;
  localparam logic [7:0] Q_T4 = 8'd204;
  localparam logic [7:0] Q_T5 = 8'd255;

  // ramp within a sector: floor(offset*255/43), offsets above 42 never occur
  localparam logic [7:0] RAMP_LUT [64] = '{
    8'd0,   8'd5,   8'd11,  8'd17,  8'd23,  8'd29,  8'd35,  8'd41,
    8'd47,  8'd53,  8'd59,  8'd65,  8'd71,  8'd77,  8'd83,  8'd88,
    8'd94,  8'd100, 8'd106, 8'd112, 8'd118, 8'd124, 8'd130, 8'd136,
    8'd142, 8'd148, 8'd154, 8'd160, 8'd166, 8'd171, 8'd177, 8'd183,
    8'd189, 8'd195, 8'd201, 8'd207, 8'd213, 8'd219, 8'd225, 8'd231,
    8'd237, 8'd243, 8'd249, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,
    8'd9,   8'd9,   8'd9,   8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,  8'd17,  8'd17,  8'd18,
    8'd18,  8'd19,  8'd19,  8'd20,  8'd20,  8'd21,  8'd22,  8'd22,  8'd23,  8'd23,  8'd24,
    8'd25,  8'd25,  8'd26,  8'd26,  8'd27,  8'd28,  8'd28,  8'd29,  8'd30,  8'd30,  8'd31,
    8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,  8'd39,
    8'd40,  8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
    8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
    8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,
    8'd71,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd81,  8'd82,  8'd83,
    8'd84,  8'd85,  8'd87,  8'd88,  8'd89,  8'd90,  8'd91,  8'd93,  8'd94,  8'd95,  8'd97,
    8'd98,  8'd99,  8'd100, 8'd102, 8'd103, 8'd105, 8'd106, 8'd107, 8'd109, 8'd110, 8'd111,
    8'd113, 8'd114, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121, 8'd123, 8'd124, 8'd126, 8'd127,
    8'd129, 8'd130, 8'd132, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd141, 8'd143, 8'd145,
    8'd146, 8'd148, 8'd149, 8'd151, 8'd153, 8'd154, 8'd156, 8'd158, 8'd159, 8'd161, 8'd163,
    8'd165, 8'd166, 8'd168, 8'd170, 8'd172, 8'd173, 8'd175, 8'd177, 8'd179, 8'd181, 8'd182,
    8'd184, 8'd186, 8'd188, 8'd190, 8'd192, 8'd194, 8'd196, 8'd197, 8'd199, 8'd201, 8'd203,
    8'd205, 8'd207, 8'd209, 8'd211, 8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd223, 8'd225,
    8'd227, 8'd229, 8'd231, 8'd234, 8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd248,
    8'd251, 8'd253, 8'd255
  };

  // stage enables handed to the per-channel shading pipe
  typedef struct packed {
    logic s2;
    logic s3;
  } hsvg_stage_en_t;

  // palette component: floor(c*5/255)
  function automatic logic [2:0] pal_quant(input logic [7:0] c);
    logic [2:0] q;
    begin
      if (c < Q_T1) begin
        q = 3'd0;
      end else if (c < Q_T2) begin
        q = 3'd1;
      end else if (c < Q_T3) begin
        q = 3'd2;
      end else if (c < Q_T4) begin
        q = 3'd3;
      end else if (c < Q_T5) begin
        q = 3'd4;
      end else begin
        q = 3'd5;
      end
      return q;
    end
  endfunction

endpackage

FILE: src/hsvg_if.sv
// hsvg_in_if / hsvg_out_if: valid/ready channels of the hsv to rgb gamma core
// no dependencies
interface hsvg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue_in;
  logic [7:0] saturation_in;
  logic [7:0] brightness_in;
  logic       gamma_enable;

  modport source (output valid, hue_in, saturation_in, brightness_in, gamma_enable,
                  input ready);
  modport sink   (input valid, hue_in, saturation_in, brightness_in, gamma_enable,
                  output ready);
endinterface

interface hsvg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] palette_index;

  modport source (output valid, red_out, green_out, blue_out, palette_index,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, palette_index,
                  output ready);
endinterface

FILE: src/hsvg_shade.sv
// hsvg_shade: saturation blend and value scaling of one colour channel, two register stages
// depends on hsvg_pkg
module hsvg_shade (
  input  logic                    clk,
  input  hsvg_pkg::hsvg_stage_en_t en,
  input  logic [7:0]              chan,
  input  logic [8:0]              sat,
  input  logic [7:0]              val,
  output logic [7:0]              scaled
);
  import hsvg_pkg::*;

  logic [16:0] blend_prod;
  logic [16:0] blend_sum;
  logic [7:0]  blend_r;
  logic [7:0]  blend_nxt;
  logic [15:0] scale_prod;
  logic [7:0]  scaled_r;
  logic [7:0]  scaled_nxt;

  // stage two: (c*s + 255*(256-s)) >> 8, never negative
  always_comb begin
    blend_prod = {8'd0, sat} * {9'd0, FULL_SCALE - chan};
    blend_sum  = BLEND_TOP - blend_prod;
    blend_nxt  = blend_sum[15:8];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      blend_r <= blend_nxt;
    end
  end

  // stage three: value scaling
  always_comb begin
    scale_prod = {8'd0, blend_r} * {8'd0, val};
    scaled_nxt = scale_prod[15:8];
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      scaled_r <= scaled_nxt;
    end
  end

  assign scaled = scaled_r;

endmodule

FILE: src/hsv_to_rgb_gamma_core.sv
// hsv_to_rgb_gamma_core: top level of the 8-bit hsv to rgb converter with gamma and palette index
// depends on hsvg_pkg, hsvg_in_if / hsvg_out_if and hsvg_shade

// Converts one 8-bit hue/saturation/value colour per clock into 8-bit red, green and blue,
// optionally through the gamma table, plus the 6x6x6 palette index of the colour before
// gamma. A transaction passes four steps from input to output: hue sector and ramp lookup,
// saturation blend, value scaling, then palette quantising and gamma lookup; each step ends
// in a register and the two multiplier steps set the clock. A new transaction is accepted on
// every cycle while the output side takes results; when the output stalls, the stages fill
// up one by one and in_chan.ready drops only once all four hold a transaction. There is no
// state between colours and no configuration; reset only clears the stage valid flags.
module hsv_to_rgb_gamma_core (
  input  logic            clk,
  input  logic            rst_n,
  hsvg_in_if.sink         in_chan,
  hsvg_out_if.source      out_chan
);
  import hsvg_pkg::*;

  // stage valid flags and enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic en1, en4;
  hsvg_stage_en_t sen;

  // stage one: sector decode and ramp
  logic [7:0] offset;
  logic [7:0] ramp_val;
  logic [7:0] r_c, g_c, b_c;
  logic [8:0] sat_c;

  logic [7:0] r1_r, g1_r, b1_r;
  logic [8:0] sat1_r;
  logic [7:0] val1_r;
  logic       gam1_r;

  // stage two carries value and gamma flag alongside the blend
  logic [7:0] val2_r;
  logic       gam2_r;
  logic       gam3_r;

  // stage three outputs from the shading pipes
  logic [7:0] r3, g3, b3;

  // stage four: palette and gamma
  logic [2:0] qr, qg, qb;
  logic [7:0] pal_nxt;
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] red_r, green_r, blue_r, pal_r;

  // ready chain: a stage may load when empty or when the next one loads
  always_comb begin
    en4    = !v4_r || out_chan.ready;
    sen.s3 = !v3_r || en4;
    sen.s2 = !v2_r || sen.s3;
    en1    = !v1_r || sen.s2;
  end

  assign in_chan.ready = en1;

  always_comb begin
    v1_nxt = en1    ? in_chan.valid : v1_r;
    v2_nxt = sen.s2 ? v1_r          : v2_r;
    v3_nxt = sen.s3 ? v2_r          : v3_r;
    v4_nxt = en4    ? v3_r          : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // hue sectors in rainbow order; one channel full, one zero, one ramps
  always_comb begin
    r_c    = 8'd0;
    g_c    = 8'd0;
    b_c    = 8'd0;
    offset = in_chan.hue_in;
    if (in_chan.hue_in < HUE_B1) begin
      offset = in_chan.hue_in;
    end else if (in_chan.hue_in < HUE_B2) begin
      offset = in_chan.hue_in - HUE_B1;
    end else if (in_chan.hue_in < HUE_B3) begin
      offset = in_chan.hue_in - HUE_B2;
    end else if (in_chan.hue_in < HUE_B4) begin
      offset = in_chan.hue_in - HUE_B3;
    end else if (in_chan.hue_in < HUE_B5) begin
      offset = in_chan.hue_in - HUE_B4;
    end else begin
      offset = in_chan.hue_in - HUE_B5;
    end
    ramp_val = RAMP_LUT[offset[5:0]];
    if (in_chan.hue_in < HUE_B1) begin
      r_c = FULL_SCALE;
      g_c = ramp_val;
    end else if (in_chan.hue_in < HUE_B2) begin
      g_c = FULL_SCALE;
      r_c = FULL_SCALE - ramp_val;
    end else if (in_chan.hue_in < HUE_B3) begin
      g_c = FULL_SCALE;
      b_c = ramp_val;
    end else if (in_chan.hue_in < HUE_B4) begin
      b_c = FULL_SCALE;
      g_c = FULL_SCALE - ramp_val;
    end else if (in_chan.hue_in < HUE_B5) begin
      b_c = FULL_SCALE;
      r_c = ramp_val;
    end else begin
      r_c = FULL_SCALE;
      b_c = FULL_SCALE - ramp_val;
    end
    // full saturation becomes 256 so the channels pass unblended
    if (in_chan.saturation_in > SAT_BUMP_LIMIT) begin
      sat_c = {1'b0, in_chan.saturation_in} + 9'd1;
    end else begin
      sat_c = {1'b0, in_chan.saturation_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      r1_r   <= r_c;
      g1_r   <= g_c;
      b1_r   <= b_c;
      sat1_r <= sat_c;
      val1_r <= in_chan.brightness_in;
      gam1_r <= in_chan.gamma_enable;
    end
  end

  // side payload that follows the blend and scale stages
  always_ff @(posedge clk) begin
    if (sen.s2) begin
      val2_r <= val1_r;
      gam2_r <= gam1_r;
    end
    if (sen.s3) begin
      gam3_r <= gam2_r;
    end
  end

  hsvg_shade u_shade_r (
    .clk    (clk),
    .en     (sen),
    .chan   (r1_r),
    .sat    (sat1_r),
    .val    (val2_r),
    .scaled (r3)
  );

  hsvg_shade u_shade_g (
    .clk    (clk),
    .en     (sen),
    .chan   (g1_r),
    .sat    (sat1_r),
    .val    (val2_r),
    .scaled (g3)
  );

  hsvg_shade u_shade_b (
    .clk    (clk),
    .en     (sen),
    .chan   (b1_r),
    .sat    (sat1_r),
    .val    (val2_r),
    .scaled (b3)
  );

  // palette index from the colour before gamma, then optional gamma lookup
  always_comb begin
    qr      = pal_quant(r3);
    qg      = pal_quant(g3);
    qb      = pal_quant(b3);
    pal_nxt = {5'd0, qr} * PAL_R_WEIGHT + {5'd0, qg} * PAL_G_WEIGHT + {5'd0, qb};
    if (gam3_r) begin
      red_nxt   = GAMMA_LUT[r3];
      green_nxt = GAMMA_LUT[g3];
      blue_nxt  = GAMMA_LUT[b3];
    end else begin
      red_nxt   = r3;
      green_nxt = g3;
      blue_nxt  = b3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      pal_r   <= pal_nxt;
    end
  end

  assign out_chan.valid         = v4_r;
  assign out_chan.red_out       = red_r;
  assign out_chan.green_out     = green_r;
  assign out_chan.blue_out      = blue_r;
  assign out_chan.palette_index = pal_r;

  // an empty output stage always lets the pipe move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v4_r |-> in_chan.ready)
    else $error("input stalled with empty output stage");

  // only a completely full pipe with a stalled output may refuse input
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (v1_r && v2_r && v3_r && v4_r && !out_chan.ready))
    else $error("input stalled while the pipe has room");

  // scaled channels never exceed 254, so the palette index stays within 172
  a_palette_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.palette_index <= 8'd172))
    else $error("palette index out of range");

  // a result that was not taken is still there on the next cycle
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !out_chan.ready) |=> v4_r)
    else $error("pending result dropped");

endmodule
